// ===== rtl/sdsh_pkg.sv =====
// Package for the SD card SPI host sequencer: phase codes, input modes,
// register indexes, command codes and the command frame builder.
// No dependencies.
`timescale 1ns / 1ps

package sdsh_pkg;

    localparam int BLOCK_BYTES    = 512;
    localparam int RESPONSE_POLLS = 32;
    localparam int WAKE_BYTES     = 10;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [7:0] BYTE_IDLE   = 8'hFF;
    localparam logic [7:0] TOKEN_START = 8'hFE;
    localparam logic [7:0] CMD_MARK    = 8'h40;
    localparam logic [7:0] R1_IDLE     = 8'h01;
    localparam logic [7:0] CRC_CMD0    = 8'h95;
    localparam logic [7:0] CRC_CMD8    = 8'h87;
    localparam logic [7:0] CRC_DUMMY   = 8'h01;
    localparam logic [31:0] ARG_CMD8   = 32'h0000_01AA;
    localparam logic [31:0] ARG_ACMD41 = 32'h4000_0000;

    localparam logic [5:0] CODE_CMD0  = 6'd0;
    localparam logic [5:0] CODE_CMD8  = 6'd8;
    localparam logic [5:0] CODE_CMD12 = 6'd12;
    localparam logic [5:0] CODE_CMD17 = 6'd17;
    localparam logic [5:0] CODE_CMD18 = 6'd18;
    localparam logic [5:0] CODE_CMD41 = 6'd41;
    localparam logic [5:0] CODE_CMD55 = 6'd55;
    localparam logic [5:0] CODE_CMD58 = 6'd58;

    typedef enum logic [1:0] {
        MODE_INIT = 2'd0,
        MODE_READ = 2'd1,
        MODE_BYTE = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REG_CMD0_LIMIT  = 2'd0,
        REG_OP_LIMIT    = 2'd1,
        REG_TOKEN_LIMIT = 2'd2,
        REG_NONE        = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        CARD_UNKNOWN = 2'd0,
        CARD_V2_SC   = 2'd1,
        CARD_V2_HC   = 2'd2
    } card_kind_t;

    typedef enum logic [4:0] {
        PH_IDLE       = 5'd0,
        PH_WAKE       = 5'd1,
        PH_CMD0       = 5'd2,
        PH_CMD8       = 5'd3,
        PH_CMD55      = 5'd4,
        PH_CMD41      = 5'd5,
        PH_CMD58      = 5'd6,
        PH_CMD17      = 5'd7,
        PH_CMD18      = 5'd8,
        PH_CMD12      = 5'd9,
        PH_CMD0_DESEL = 5'd10,
        PH_OCR        = 5'd11,
        PH_OCR_DESEL  = 5'd12,
        PH_INIT_END   = 5'd13,
        PH_TOKEN      = 5'd14,
        PH_DATA       = 5'd15,
        PH_CRC        = 5'd16,
        PH_READ_END   = 5'd17
    } phase_t;

    function automatic logic [7:0] frame_byte(
        input phase_t      ph,
        input logic [2:0]  idx,
        input logic [31:0] addr
    );
        logic [5:0]  code;
        logic [31:0] arg;
        logic [7:0]  crc;
        code = CODE_CMD12;
        arg  = '0;
        crc  = CRC_DUMMY;
        unique case (ph)
            PH_CMD0:
            begin
                code = CODE_CMD0;
                crc  = CRC_CMD0;
            end
            PH_CMD8:
            begin
                code = CODE_CMD8;
                arg  = ARG_CMD8;
                crc  = CRC_CMD8;
            end
            PH_CMD55: code = CODE_CMD55;
            PH_CMD41:
            begin
                code = CODE_CMD41;
                arg  = ARG_ACMD41;
            end
            PH_CMD58: code = CODE_CMD58;
            PH_CMD17:
            begin
                code = CODE_CMD17;
                arg  = addr;
            end
            PH_CMD18:
            begin
                code = CODE_CMD18;
                arg  = addr;
            end
            default: code = CODE_CMD12;
        endcase
        unique case (idx)
            3'd1:    frame_byte = {2'b00, code} | CMD_MARK;
            3'd2:    frame_byte = arg[31:24];
            3'd3:    frame_byte = arg[23:16];
            3'd4:    frame_byte = arg[15:8];
            3'd5:    frame_byte = arg[7:0];
            default: frame_byte = crc;
        endcase
    endfunction

endpackage

// ===== rtl/sd_spi_host_init_and_read.sv =====
// SD card SPI-mode host sequencer: initialization and single/multi block reads.
// Depends on sdsh_pkg.
// Each result is registered and shown in the cycle after its input is accepted.
// Throughput: one transaction per cycle while in_ready is high; the next-byte
// decision is one pass of logic from the state registers into the result register.
// Reset (rst_n low, asynchronous): phase idle, counters and card state zero,
// limits back to 20 / 65534 / 65535, result register empty.
`timescale 1ns / 1ps

module sd_spi_host_init_and_read
    import sdsh_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            mode,
    input  logic [31:0]           sector,
    input  logic [7:0]            block_count,
    input  logic [7:0]            rx_byte,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  tx_valid,
    output logic [7:0]            tx_byte,
    output logic                  chip_select,
    output logic                  data_valid,
    output logic [7:0]            data_byte,
    output logic                  done_res,
    output logic [7:0]            result_code,
    output logic [1:0]            card_type,
    output logic                  fast_clock,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam logic [9:0] BLOCK_LAST = 10'((BLOCK_BYTES - 1) & 10'h3FF);
    localparam logic [9:0] WAKE_N     = 10'(WAKE_BYTES);
    localparam logic [15:0] POLLS_N   = 16'(RESPONSE_POLLS);

    logic [7:0]  cmd0_limit_reg;
    logic [15:0] op_limit_reg;
    logic [15:0] token_limit_reg;

    phase_t      phase_reg, phase_next;
    logic [9:0]  byte_counter_reg, byte_counter_next;
    logic [15:0] retry_counter_reg, retry_counter_next;
    logic [15:0] poll_counter_reg, poll_counter_next;
    logic [8:0]  blocks_left_reg, blocks_left_next;
    logic [1:0]  card_kind_reg, card_kind_next;
    logic [7:0]  last_response_reg, last_response_next;
    logic [31:0] byte_address_reg, byte_address_next;
    logic        init_ok_reg, init_ok_next;
    logic        op_ok_reg, op_ok_next;

    logic        out_valid_reg;
    logic        tx_valid_reg, tx_valid_next;
    logic [7:0]  tx_byte_reg, tx_byte_next;
    logic        chip_select_reg, chip_select_next;
    logic        data_valid_reg, data_valid_next;
    logic [7:0]  data_byte_reg, data_byte_next;
    logic        done_reg, done_next;
    logic [7:0]  result_code_reg, result_code_next;

    logic        in_fire;
    logic        cfg_write;
    reg_index_t  cfg_index;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = reg_index_t'(paddr[3:2]);

    always_comb
    begin
        unique case (cfg_index)
            REG_CMD0_LIMIT:  prdata = {24'd0, cmd0_limit_reg};
            REG_OP_LIMIT:    prdata = {16'd0, op_limit_reg};
            REG_TOKEN_LIMIT: prdata = {16'd0, token_limit_reg};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd0_limit_reg  <= 8'd20;
            op_limit_reg    <= 16'd65534;
            token_limit_reg <= 16'd65535;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_CMD0_LIMIT:  cmd0_limit_reg  <= pwdata[7:0];
                REG_OP_LIMIT:    op_limit_reg    <= pwdata[15:0];
                REG_TOKEN_LIMIT: token_limit_reg <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        phase_next         = phase_reg;
        byte_counter_next  = byte_counter_reg;
        retry_counter_next = retry_counter_reg;
        poll_counter_next  = poll_counter_reg;
        blocks_left_next   = blocks_left_reg;
        card_kind_next     = card_kind_reg;
        last_response_next = last_response_reg;
        byte_address_next  = byte_address_reg;
        init_ok_next       = init_ok_reg;
        op_ok_next         = op_ok_reg;
        tx_valid_next      = 1'b0;
        tx_byte_next       = 8'd0;
        chip_select_next   = 1'b1;
        data_valid_next    = 1'b0;
        data_byte_next     = 8'd0;
        done_next          = 1'b0;
        result_code_next   = 8'd0;

        priority if (mode_t'(mode) == MODE_INIT)
        begin
            init_ok_next      = 1'b0;
            op_ok_next        = 1'b0;
            phase_next        = PH_WAKE;
            byte_counter_next = '0;
            tx_valid_next     = 1'b1;
            tx_byte_next      = BYTE_IDLE;
        end
        else if (mode_t'(mode) == MODE_READ)
        begin
            byte_address_next  = (card_kind_reg == CARD_V2_HC) ? sector : {sector[22:0], 9'd0};
            last_response_next = '0;
            byte_counter_next  = '0;
            poll_counter_next  = '0;
            tx_valid_next      = 1'b1;
            tx_byte_next       = BYTE_IDLE;
            if (block_count == 8'd1)
            begin
                blocks_left_next = '0;
                phase_next       = PH_CMD17;
            end
            else
            begin
                blocks_left_next = (block_count == 8'd0) ? 9'd256 : {1'b0, block_count};
                phase_next       = PH_CMD18;
            end
        end
        else if (mode_t'(mode) == MODE_BYTE && phase_reg != PH_IDLE)
        begin
            unique case (phase_reg)
                PH_WAKE:
                begin
                    tx_valid_next = 1'b1;
                    tx_byte_next  = BYTE_IDLE;
                    if (byte_counter_reg < WAKE_N)
                    begin
                        byte_counter_next = byte_counter_reg + 10'd1;
                    end
                    else
                    begin
                        retry_counter_next = {8'd0, cmd0_limit_reg};
                        phase_next         = PH_CMD0;
                        byte_counter_next  = '0;
                        poll_counter_next  = '0;
                    end
                end
                PH_CMD0_DESEL:
                begin
                    tx_valid_next = 1'b1;
                    tx_byte_next  = BYTE_IDLE;
                    if (last_response_reg == R1_IDLE)
                    begin
                        card_kind_next    = CARD_UNKNOWN;
                        phase_next        = PH_CMD8;
                        byte_counter_next = '0;
                        poll_counter_next = '0;
                    end
                    else if (retry_counter_reg != 16'd0)
                    begin
                        retry_counter_next = retry_counter_reg - 16'd1;
                        phase_next         = PH_CMD0;
                        byte_counter_next  = '0;
                        poll_counter_next  = '0;
                    end
                    else
                    begin
                        card_kind_next = CARD_UNKNOWN;
                        phase_next     = PH_INIT_END;
                    end
                end
                PH_OCR:
                begin
                    if (byte_counter_reg == 10'd0)
                    begin
                        last_response_next = rx_byte;
                    end
                    byte_counter_next = byte_counter_reg + 10'd1;
                    tx_valid_next     = 1'b1;
                    tx_byte_next      = BYTE_IDLE;
                    if (byte_counter_reg + 10'd1 < 10'd4)
                    begin
                        chip_select_next = 1'b0;
                    end
                    else
                    begin
                        phase_next = PH_OCR_DESEL;
                    end
                end
                PH_OCR_DESEL:
                begin
                    card_kind_next = last_response_reg[6] ? CARD_V2_HC : CARD_V2_SC;
                    phase_next     = PH_INIT_END;
                    tx_valid_next  = 1'b1;
                    tx_byte_next   = BYTE_IDLE;
                end
                PH_INIT_END:
                begin
                    init_ok_next     = 1'b1;
                    phase_next       = PH_IDLE;
                    done_next        = 1'b1;
                    result_code_next = {7'd0, op_ok_reg};
                end
                PH_TOKEN:
                begin
                    tx_valid_next = 1'b1;
                    tx_byte_next  = BYTE_IDLE;
                    if (rx_byte == TOKEN_START && poll_counter_reg != 16'd0)
                    begin
                        phase_next        = PH_DATA;
                        byte_counter_next = BLOCK_LAST;
                        chip_select_next  = 1'b0;
                    end
                    else if (poll_counter_reg == 16'd0)
                    begin
                        last_response_next = R1_IDLE;
                        if (blocks_left_reg == 9'd0)
                        begin
                            phase_next = PH_READ_END;
                        end
                        else
                        begin
                            blocks_left_next  = blocks_left_reg - 9'd1;
                            phase_next        = PH_CMD12;
                            byte_counter_next = '0;
                            poll_counter_next = '0;
                        end
                    end
                    else
                    begin
                        poll_counter_next = poll_counter_reg - 16'd1;
                        chip_select_next  = 1'b0;
                    end
                end
                PH_DATA:
                begin
                    data_valid_next  = 1'b1;
                    data_byte_next   = rx_byte;
                    tx_valid_next    = 1'b1;
                    tx_byte_next     = BYTE_IDLE;
                    chip_select_next = 1'b0;
                    if (byte_counter_reg != 10'd0)
                    begin
                        byte_counter_next = byte_counter_reg - 10'd1;
                    end
                    else
                    begin
                        phase_next        = PH_CRC;
                        byte_counter_next = '0;
                    end
                end
                PH_CRC:
                begin
                    tx_valid_next = 1'b1;
                    tx_byte_next  = BYTE_IDLE;
                    if (byte_counter_reg == 10'd0)
                    begin
                        byte_counter_next = 10'd1;
                        chip_select_next  = 1'b0;
                    end
                    else
                    begin
                        last_response_next = '0;
                        if (blocks_left_reg == 9'd0)
                        begin
                            phase_next = PH_READ_END;
                        end
                        else
                        begin
                            blocks_left_next = blocks_left_reg - 9'd1;
                            if (blocks_left_reg != 9'd1)
                            begin
                                phase_next        = PH_TOKEN;
                                poll_counter_next = token_limit_reg;
                                chip_select_next  = 1'b0;
                            end
                            else
                            begin
                                phase_next        = PH_CMD12;
                                byte_counter_next = '0;
                                poll_counter_next = '0;
                            end
                        end
                    end
                end
                PH_READ_END:
                begin
                    phase_next       = PH_IDLE;
                    done_next        = 1'b1;
                    result_code_next = last_response_reg;
                end
                PH_CMD0, PH_CMD8, PH_CMD55, PH_CMD41, PH_CMD58,
                PH_CMD17, PH_CMD18, PH_CMD12:
                begin
                    tx_valid_next = 1'b1;
                    tx_byte_next  = BYTE_IDLE;
                    priority if (byte_counter_reg < 10'd6)
                    begin
                        byte_counter_next = byte_counter_reg + 10'd1;
                        tx_byte_next      = frame_byte(phase_reg, byte_counter_next[2:0],
                                                       byte_address_reg);
                        chip_select_next  = 1'b0;
                    end
                    else if (byte_counter_reg == 10'd6)
                    begin
                        byte_counter_next = 10'd7;
                        poll_counter_next = '0;
                        chip_select_next  = 1'b0;
                    end
                    else
                    begin
                        poll_counter_next = poll_counter_reg + 16'd1;
                        if (rx_byte[7] && poll_counter_next < POLLS_N)
                        begin
                            chip_select_next = 1'b0;
                        end
                        else
                        begin
                            unique case (phase_reg)
                                PH_CMD0:
                                begin
                                    last_response_next = rx_byte;
                                    phase_next         = PH_CMD0_DESEL;
                                end
                                PH_CMD8:
                                begin
                                    if (rx_byte == R1_IDLE)
                                    begin
                                        retry_counter_next = op_limit_reg;
                                        phase_next         = PH_CMD55;
                                        byte_counter_next  = '0;
                                        poll_counter_next  = '0;
                                    end
                                    else
                                    begin
                                        phase_next = PH_INIT_END;
                                    end
                                end
                                PH_CMD55:
                                begin
                                    phase_next        = PH_CMD41;
                                    byte_counter_next = '0;
                                    poll_counter_next = '0;
                                end
                                PH_CMD41:
                                begin
                                    last_response_next = rx_byte;
                                    byte_counter_next  = '0;
                                    poll_counter_next  = '0;
                                    if (rx_byte != 8'd0 && retry_counter_reg != 16'd0)
                                    begin
                                        retry_counter_next = retry_counter_reg - 16'd1;
                                        phase_next         = PH_CMD55;
                                    end
                                    else
                                    begin
                                        op_ok_next = (rx_byte == 8'd0);
                                        phase_next = PH_CMD58;
                                    end
                                end
                                PH_CMD58:
                                begin
                                    if (rx_byte == 8'd0)
                                    begin
                                        phase_next        = PH_OCR;
                                        byte_counter_next = '0;
                                        chip_select_next  = 1'b0;
                                    end
                                    else
                                    begin
                                        phase_next = PH_INIT_END;
                                    end
                                end
                                PH_CMD17:
                                begin
                                    last_response_next = rx_byte;
                                    if (rx_byte == 8'd0)
                                    begin
                                        phase_next        = PH_TOKEN;
                                        poll_counter_next = token_limit_reg;
                                        chip_select_next  = 1'b0;
                                    end
                                    else
                                    begin
                                        phase_next = PH_READ_END;
                                    end
                                end
                                PH_CMD18:
                                begin
                                    phase_next        = PH_TOKEN;
                                    poll_counter_next = token_limit_reg;
                                    chip_select_next  = 1'b0;
                                end
                                default:
                                begin
                                    phase_next = PH_READ_END;
                                end
                            endcase
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
        else
        begin
            // hold state for an idle byte step or an unused mode
            phase_next = phase_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            byte_counter_reg  <= '0;
            retry_counter_reg <= '0;
            poll_counter_reg  <= '0;
            blocks_left_reg   <= '0;
            card_kind_reg     <= CARD_UNKNOWN;
            last_response_reg <= '0;
            byte_address_reg  <= '0;
            init_ok_reg       <= 1'b0;
            op_ok_reg         <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg         <= phase_next;
            byte_counter_reg  <= byte_counter_next;
            retry_counter_reg <= retry_counter_next;
            poll_counter_reg  <= poll_counter_next;
            blocks_left_reg   <= blocks_left_next;
            card_kind_reg     <= card_kind_next;
            last_response_reg <= last_response_next;
            byte_address_reg  <= byte_address_next;
            init_ok_reg       <= init_ok_next;
            op_ok_reg         <= op_ok_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // load result payload with each accepted transaction
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            tx_valid_reg    <= tx_valid_next;
            tx_byte_reg     <= tx_byte_next;
            chip_select_reg <= chip_select_next;
            data_valid_reg  <= data_valid_next;
            data_byte_reg   <= data_byte_next;
            done_reg        <= done_next;
            result_code_reg <= result_code_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign tx_valid    = tx_valid_reg;
    assign tx_byte     = tx_byte_reg;
    assign chip_select = chip_select_reg;
    assign data_valid  = data_valid_reg;
    assign data_byte   = data_byte_reg;
    assign done_res    = done_reg;
    assign result_code = result_code_reg;
    assign card_type   = card_kind_reg;
    assign fast_clock  = init_ok_reg;

endmodule

// ===== rtl/sdsh_checker.sv =====
// Port-level checker for the SD card SPI host sequencer, bound to the top level.
// Depends on sdsh_pkg and sd_spi_host_init_and_read.
`timescale 1ns / 1ps

module sdsh_checker
    import sdsh_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic                  tx_valid,
    input logic [7:0]            tx_byte,
    input logic                  chip_select,
    input logic                  data_valid,
    input logic [7:0]            data_byte,
    input logic                  done_res,
    input logic [7:0]            result_code
);

    // accept whenever the result register is free or being drained
    a_ready_skid: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow result register occupancy");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(result_code)
                                    && $stable(done_res))
        else $error("stalled result transaction changed");

    a_idle_link: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !tx_valid |-> tx_byte == 8'd0 && chip_select)
        else $error("no exchange requested but link fields are not idle");

    a_done_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !tx_valid && !data_valid)
        else $error("completion reported together with an exchange or payload");

    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (done_res || result_code == 8'd0) && (data_valid || data_byte == 8'd0))
        else $error("unused result fields are not zero");

endmodule

bind sd_spi_host_init_and_read sdsh_checker u_sdsh_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .tx_valid    (tx_valid),
    .tx_byte     (tx_byte),
    .chip_select (chip_select),
    .data_valid  (data_valid),
    .data_byte   (data_byte),
    .done_res    (done_res),
    .result_code (result_code)
);

// ===== dv/testbench.sv =====
// Self-checking testbench for the SD card SPI host sequencer: plays the card side of the
// byte link, predicts every step result and compares it with the DUT output.
// Depends on sdsh_pkg and sd_spi_host_init_and_read.
`timescale 1ns / 1ps

module testbench;
    import sdsh_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int RANDOM_ITEMS = 1300;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_PRINTS   = 60;
    localparam logic [7:0] R1_READY     = 8'h00;
    localparam logic [7:0] RES_NO_TOKEN = 8'h01;

    typedef struct packed {
        mode_t       mode;
        logic [31:0] sector;
        logic [7:0]  block_count;
        logic [7:0]  rx_byte;
    } link_item_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       chip_select;
        logic       data_valid;
        logic [7:0] data_byte;
        logic       done_res;
        logic [7:0] result_code;
        logic [1:0] card_type;
        logic       fast_clock;
    } link_step_t;

    class sd_scoreboard;
        logic [7:0]  cmd0_lim;
        logic [15:0] op_lim;
        logic [15:0] tok_lim;
        phase_t      ph;
        logic [9:0]  byte_cnt;
        logic [15:0] retry_cnt;
        logic [15:0] poll_cnt;
        logic [8:0]  blocks_left;
        card_kind_t  kind;
        logic [7:0]  last_r1;
        logic [31:0] byte_addr;
        logic        init_done;
        logic        init_pass;
        link_step_t  nxt;
        link_step_t  step_q[$];
        int          errors;
        int          result_no;

        function new();
            cmd0_lim    = 8'd20;
            op_lim      = 16'd65534;
            tok_lim     = 16'd65535;
            ph          = PH_IDLE;
            byte_cnt    = '0;
            retry_cnt   = '0;
            poll_cnt    = '0;
            blocks_left = '0;
            kind        = CARD_UNKNOWN;
            last_r1     = '0;
            byte_addr   = '0;
            init_done   = 1'b0;
            init_pass   = 1'b0;
            errors      = 0;
            result_no   = 0;
        endfunction

        function void set_limit(reg_index_t idx, logic [31:0] v);
            case (idx)
                REG_CMD0_LIMIT:  cmd0_lim = v[7:0];
                REG_OP_LIMIT:    op_lim   = v[15:0];
                REG_TOKEN_LIMIT: tok_lim  = v[15:0];
                default: ;
            endcase
        endfunction

        function void request(logic [7:0] b, logic cs);
            nxt.tx_valid    = 1'b1;
            nxt.tx_byte     = b;
            nxt.chip_select = cs;
        endfunction

        function void begin_cmd(phase_t p);
            ph       = p;
            byte_cnt = '0;
            poll_cnt = '0;
            request(BYTE_IDLE, 1'b1);
        endfunction

        function void finish_with(phase_t p);
            ph = p;
            request(BYTE_IDLE, 1'b1);
        endfunction

        function void begin_token();
            ph       = PH_TOKEN;
            poll_cnt = tok_lim;
            request(BYTE_IDLE, 1'b0);
        endfunction

        function logic [7:0] frame(int idx);
            logic [5:0]  code;
            logic [31:0] arg;
            logic [7:0]  crc;
            code = CODE_CMD12;
            arg  = '0;
            crc  = CRC_DUMMY;
            case (ph)
                PH_CMD0:
                begin
                    code = CODE_CMD0;
                    crc  = CRC_CMD0;
                end
                PH_CMD8:
                begin
                    code = CODE_CMD8;
                    arg  = ARG_CMD8;
                    crc  = CRC_CMD8;
                end
                PH_CMD55: code = CODE_CMD55;
                PH_CMD41:
                begin
                    code = CODE_CMD41;
                    arg  = ARG_ACMD41;
                end
                PH_CMD58: code = CODE_CMD58;
                PH_CMD17:
                begin
                    code = CODE_CMD17;
                    arg  = byte_addr;
                end
                PH_CMD18:
                begin
                    code = CODE_CMD18;
                    arg  = byte_addr;
                end
                default: code = CODE_CMD12;
            endcase
            if (idx == 1)
                return {2'b00, code} | CMD_MARK;
            if (idx >= 2 && idx <= 5)
                return 8'(arg >> (8 * (5 - idx)));
            return crc;
        endfunction

        function void next_block();
            if (blocks_left == 0)
            begin
                finish_with(PH_READ_END);
                return;
            end
            blocks_left--;
            if (blocks_left != 0 && last_r1 == R1_READY)
                begin_token();
            else
                begin_cmd(PH_CMD12);
        endfunction

        function void take_r1(logic [7:0] r1);
            case (ph)
                PH_CMD0:
                begin
                    last_r1 = r1;
                    finish_with(PH_CMD0_DESEL);
                end
                PH_CMD8:
                begin
                    if (r1 == R1_IDLE)
                    begin
                        retry_cnt = op_lim;
                        begin_cmd(PH_CMD55);
                    end
                    else
                        finish_with(PH_INIT_END);
                end
                PH_CMD55: begin_cmd(PH_CMD41);
                PH_CMD41:
                begin
                    last_r1 = r1;
                    if (r1 != R1_READY && retry_cnt != 0)
                    begin
                        retry_cnt--;
                        begin_cmd(PH_CMD55);
                    end
                    else
                    begin
                        init_pass = (r1 == R1_READY);
                        begin_cmd(PH_CMD58);
                    end
                end
                PH_CMD58:
                begin
                    if (r1 == R1_READY)
                    begin
                        ph       = PH_OCR;
                        byte_cnt = '0;
                        request(BYTE_IDLE, 1'b0);
                    end
                    else
                        finish_with(PH_INIT_END);
                end
                PH_CMD17:
                begin
                    last_r1 = r1;
                    if (r1 == R1_READY)
                        begin_token();
                    else
                        finish_with(PH_READ_END);
                end
                PH_CMD18: begin_token();
                default:  finish_with(PH_READ_END);
            endcase
        endfunction

        function void byte_step(logic [7:0] rx);
            case (ph)
                PH_WAKE:
                begin
                    if (byte_cnt < WAKE_BYTES)
                    begin
                        byte_cnt++;
                        request(BYTE_IDLE, 1'b1);
                    end
                    else
                    begin
                        retry_cnt = 16'(cmd0_lim);
                        begin_cmd(PH_CMD0);
                    end
                end
                PH_CMD0_DESEL:
                begin
                    if (last_r1 == R1_IDLE)
                    begin
                        kind = CARD_UNKNOWN;
                        begin_cmd(PH_CMD8);
                    end
                    else if (retry_cnt != 0)
                    begin
                        retry_cnt--;
                        begin_cmd(PH_CMD0);
                    end
                    else
                    begin
                        kind = CARD_UNKNOWN;
                        finish_with(PH_INIT_END);
                    end
                end
                PH_OCR:
                begin
                    if (byte_cnt == 0)
                        last_r1 = rx;
                    byte_cnt++;
                    if (byte_cnt < 4)
                        request(BYTE_IDLE, 1'b0);
                    else
                        finish_with(PH_OCR_DESEL);
                end
                PH_OCR_DESEL:
                begin
                    kind = last_r1[6] ? CARD_V2_HC : CARD_V2_SC;
                    finish_with(PH_INIT_END);
                end
                PH_INIT_END:
                begin
                    init_done       = 1'b1;
                    ph              = PH_IDLE;
                    nxt.done_res    = 1'b1;
                    nxt.result_code = {7'd0, init_pass};
                end
                PH_TOKEN:
                begin
                    if (rx == TOKEN_START && poll_cnt != 0)
                    begin
                        ph       = PH_DATA;
                        byte_cnt = 10'(BLOCK_BYTES - 1);
                        request(BYTE_IDLE, 1'b0);
                    end
                    else if (poll_cnt == 0)
                    begin
                        last_r1 = RES_NO_TOKEN;
                        next_block();
                    end
                    else
                    begin
                        poll_cnt--;
                        request(BYTE_IDLE, 1'b0);
                    end
                end
                PH_DATA:
                begin
                    nxt.data_valid = 1'b1;
                    nxt.data_byte  = rx;
                    if (byte_cnt != 0)
                        byte_cnt--;
                    else
                    begin
                        ph       = PH_CRC;
                        byte_cnt = '0;
                    end
                    request(BYTE_IDLE, 1'b0);
                end
                PH_CRC:
                begin
                    if (byte_cnt == 0)
                    begin
                        byte_cnt = 10'd1;
                        request(BYTE_IDLE, 1'b0);
                    end
                    else
                    begin
                        last_r1 = R1_READY;
                        next_block();
                    end
                end
                PH_READ_END:
                begin
                    ph              = PH_IDLE;
                    nxt.done_res    = 1'b1;
                    nxt.result_code = last_r1;
                end
                default:
                begin
                    if (ph >= PH_CMD0 && ph <= PH_CMD12)
                    begin
                        if (byte_cnt < 6)
                        begin
                            byte_cnt++;
                            request(frame(int'(byte_cnt)), 1'b0);
                        end
                        else if (byte_cnt == 6)
                        begin
                            byte_cnt = 10'd7;
                            poll_cnt = '0;
                            request(BYTE_IDLE, 1'b0);
                        end
                        else
                        begin
                            poll_cnt++;
                            if (rx[7] && poll_cnt < RESPONSE_POLLS)
                                request(BYTE_IDLE, 1'b0);
                            else
                                take_r1(rx);
                        end
                    end
                    else
                        ph = PH_IDLE;
                end
            endcase
        endfunction

        function void note_input(link_item_t it);
            nxt             = '0;
            nxt.chip_select = 1'b1;
            case (it.mode)
                MODE_INIT:
                begin
                    init_done = 1'b0;
                    init_pass = 1'b0;
                    ph        = PH_WAKE;
                    byte_cnt  = '0;
                    request(BYTE_IDLE, 1'b1);
                end
                MODE_READ:
                begin
                    byte_addr = (kind == CARD_V2_HC) ? it.sector : it.sector << 9;
                    last_r1   = R1_READY;
                    if (it.block_count == 8'd1)
                    begin
                        blocks_left = '0;
                        begin_cmd(PH_CMD17);
                    end
                    else
                    begin
                        blocks_left = (it.block_count == 0) ? 9'd256 : 9'(it.block_count);
                        begin_cmd(PH_CMD18);
                    end
                end
                MODE_BYTE:
                begin
                    if (ph != PH_IDLE)
                        byte_step(it.rx_byte);
                end
                default: ;
            endcase
            nxt.card_type  = kind;
            nxt.fast_clock = init_done;
            step_q.push_back(nxt);
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTS)
                $display("ERROR at %0t ns: %s", $time, msg);
            errors++;
        endtask

        task compare_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report($sformatf("result %0d %s: got %0h, want %0h", result_no, name, got, want));
        endtask

        task check_result(link_step_t got);
            link_step_t want;
            if (step_q.size() == 0)
            begin
                report("result with no transaction waiting");
                return;
            end
            want = step_q.pop_front();
            compare_field("tx_valid", 8'(got.tx_valid), 8'(want.tx_valid));
            compare_field("tx_byte", got.tx_byte, want.tx_byte);
            compare_field("chip_select", 8'(got.chip_select), 8'(want.chip_select));
            compare_field("data_valid", 8'(got.data_valid), 8'(want.data_valid));
            compare_field("data_byte", got.data_byte, want.data_byte);
            compare_field("done_res", 8'(got.done_res), 8'(want.done_res));
            compare_field("result_code", got.result_code, want.result_code);
            compare_field("card_type", 8'(got.card_type), 8'(want.card_type));
            compare_field("fast_clock", 8'(got.fast_clock), 8'(want.fast_clock));
            result_no++;
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [1:0]            mode;
    logic [31:0]           sector;
    logic [7:0]            block_count;
    logic [7:0]            rx_byte;
    logic                  out_valid;
    logic                  out_ready;
    logic                  tx_valid;
    logic [7:0]            tx_byte;
    logic                  chip_select;
    logic                  data_valid;
    logic [7:0]            data_byte;
    logic                  done_res;
    logic [7:0]            result_code;
    logic [1:0]            card_type;
    logic                  fast_clock;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    sd_scoreboard sb;
    int           send_idle;
    int           recv_idle;
    int           work_items;
    int           phase_end;
    int           hold_requests;
    int           busy_polls;
    int           token_delay;
    int           cycle_count;

    sd_spi_host_init_and_read dut (.*);

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic link_item_t make_item(mode_t m, logic [31:0] s, logic [7:0] c,
                                             logic [7:0] r);
        link_item_t it;
        it.mode        = m;
        it.sector      = s;
        it.block_count = c;
        it.rx_byte     = r;
        return it;
    endfunction

    function automatic link_item_t rand_item(mode_t m);
        return make_item(m, $urandom, 8'($urandom), 8'($urandom));
    endfunction

    function automatic logic [7:0] card_r1(phase_t p);
        logic       bad;
        logic [7:0] junk;
        bad  = ($urandom_range(0, 99) < 12);
        junk = 8'($urandom_range(0, 127));
        case (p)
            PH_CMD0, PH_CMD8:  return bad ? junk : R1_IDLE;
            PH_CMD41:
                return bad ? junk : (($urandom_range(0, 99) < 55) ? R1_IDLE : R1_READY);
            PH_CMD58, PH_CMD17: return bad ? junk : R1_READY;
            default:            return junk;
        endcase
    endfunction

    function automatic logic [7:0] card_reply();
        logic [7:0] junk;
        junk = 8'($urandom);
        if (sb.ph >= PH_CMD0 && sb.ph <= PH_CMD12 && sb.byte_cnt == 7)
        begin
            if (sb.poll_cnt == 0)
                busy_polls = ($urandom_range(0, 99) < 4) ? RESPONSE_POLLS + 2
                                                        : $urandom_range(0, 3);
            if (busy_polls > 0)
            begin
                busy_polls--;
                return junk | 8'h80;
            end
            return card_r1(sb.ph);
        end
        if (sb.ph == PH_TOKEN)
        begin
            if (sb.poll_cnt == sb.tok_lim)
                token_delay = ($urandom_range(0, 3) == 0 && sb.tok_lim <= 8)
                              ? int'(sb.tok_lim) : $urandom_range(0, 3);
            if (token_delay > 0)
            begin
                token_delay--;
                return (junk == TOKEN_START || $urandom_range(0, 3) != 0) ? BYTE_IDLE : junk;
            end
            return ($urandom_range(0, 19) == 0) ? junk : TOKEN_START;
        end
        return junk;
    endfunction

    task automatic drive_item(link_item_t it);
        bit counted;
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= it.mode;
        sector      <= it.sector;
        block_count <= it.block_count;
        rx_byte     <= it.rx_byte;
        do
            @(posedge clk);
        while (!in_ready);
        counted = (it.mode != MODE_NONE) && !(it.mode == MODE_BYTE && sb.ph == PH_IDLE);
        sb.note_input(it);
        if (counted)
            work_items++;
    endtask

    task automatic card_step();
        link_item_t it;
        it         = rand_item(MODE_BYTE);
        it.rx_byte = card_reply();
        drive_item(it);
    endtask

    task automatic pause_until_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.step_q.size() != 0);
    endtask

    task automatic write_limit(reg_index_t idx, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(4 * int'(idx));
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_limit(idx, v);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== v)
            sb.report($sformatf("register %0d read back %0h, want %0h", idx, prdata, v));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_scenario();
        int         pick;
        int         cap;
        int         steps;
        link_item_t it;
        pick = $urandom_range(0, 99);
        if (pick < 6)
        begin
            drive_item(rand_item($urandom_range(0, 1) ? MODE_NONE : MODE_BYTE));
            return;
        end
        if (pick < 40)
        begin
            it  = rand_item(MODE_INIT);
            cap = ($urandom_range(0, 99) < 85) ? 4000 : $urandom_range(1, 60);
        end
        else
        begin
            it   = rand_item(MODE_READ);
            pick = $urandom_range(0, 99);
            if (pick < 55)
                it.block_count = 8'd1;
            else if (pick < 85)
                it.block_count = 8'($urandom_range(2, 4));
            else if (pick < 92)
                it.block_count = 8'd0;
            else if (pick < 96)
                it.block_count = 8'd255;
            pick = $urandom_range(0, 3);
            if (pick == 0)
                it.sector = '0;
            else if (pick == 1)
                it.sector = '1;
            pick = $urandom_range(0, 99);
            if (pick < 15 && it.block_count >= 1 && it.block_count <= 3)
                cap = 2500;
            else if (pick < 40)
                cap = $urandom_range(40, 700);
            else
                cap = $urandom_range(1, 40);
        end
        drive_item(it);
        steps = 0;
        while (sb.ph != PH_IDLE && steps < cap && work_items < phase_end)
        begin
            if ($urandom_range(0, 99) == 0)
                drive_item(rand_item(MODE_NONE));
            card_step();
            steps++;
        end
    endtask

    task automatic run_phase(int budget);
        int first;
        bit paused;
        first     = work_items;
        phase_end = first + budget;
        paused    = 1'b0;
        hold_requests++;
        while (work_items - first < budget)
        begin
            if (!paused && work_items - first > 2 * budget / 3)
            begin
                pause_until_drained();
                paused = 1'b1;
            end
            run_scenario();
        end
    endtask

    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_result({tx_valid, tx_byte, chip_select, data_valid, data_byte,
                                 done_res, result_code, card_type, fast_clock});
            if (hold_seen != hold_requests)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        sb            = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        mode          = MODE_BYTE;
        sector        = '0;
        block_count   = '0;
        rx_byte       = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        send_idle     = 0;
        recv_idle     = 0;
        work_items    = 0;
        phase_end     = 0;
        hold_requests = 0;
        busy_polls    = 0;
        token_delay   = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        drive_item(make_item(MODE_BYTE, '0, '0, '0));
        drive_item(make_item(MODE_NONE, '1, '1, '1));
        drive_item(make_item(MODE_READ, '1, 8'd0, 8'h00));
        repeat (5) drive_item(make_item(MODE_BYTE, '1, '1, BYTE_IDLE));
        drive_item(make_item(MODE_READ, '0, 8'd1, '1));
        repeat (3) card_step();
        drive_item(make_item(MODE_READ, 32'h1234_5678, 8'd255, 8'h7F));
        repeat (2) card_step();
        drive_item(make_item(MODE_INIT, '0, '0, TOKEN_START));
        repeat (8) card_step();
        drive_item(make_item(MODE_NONE, '0, '0, '0));
        drive_item(make_item(MODE_BYTE, '0, '0, 8'h80));

        for (int p = 0; p < 3; p++)
        begin
            pause_until_drained();
            repeat (2) @(posedge clk);
            if (p == 0)
            begin
                write_limit(REG_CMD0_LIMIT, 32'd255);
                write_limit(REG_OP_LIMIT, 32'd65535);
                write_limit(REG_TOKEN_LIMIT, 32'd65535);
                send_idle = 34;
                recv_idle = 66;
            end
            else if (p == 1)
            begin
                write_limit(REG_CMD0_LIMIT, 32'd0);
                write_limit(REG_OP_LIMIT, 32'd0);
                write_limit(REG_TOKEN_LIMIT, 32'd0);
                send_idle = 66;
                recv_idle = 34;
            end
            else
            begin
                write_limit(REG_CMD0_LIMIT, 32'($urandom_range(1, 4)));
                write_limit(REG_OP_LIMIT, 32'($urandom_range(1, 6)));
                write_limit(REG_TOKEN_LIMIT, 32'($urandom_range(1, 5)));
                send_idle = 0;
                recv_idle = 0;
            end
            run_phase(RANDOM_ITEMS / 3);
        end

        pause_until_drained();
        repeat (4) @(posedge clk);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
